// ===== rtl/core/ftrm_pkg.sv =====
`timescale 1ns / 1ps

package ftrm_pkg;

	localparam int CNT_W  = 8;
	localparam int TIME_W = 64;
	localparam int WIN_W  = 32;
	localparam int RPM_W  = 20;
	localparam int NUM_W  = 44;
	localparam int STEP_W = 6;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [35:0]      NS_PER_MINUTE = 36'd60000000000;
	localparam logic [RPM_W-1:0] RPM_MAX       = {RPM_W{1'b1}};

	localparam logic [CNT_W-1:0] EDGE_LIMIT_RST = 8'd17;
	localparam logic [WIN_W-1:0] WINDOW_RST     = 32'd500000000;

	localparam logic REG_EDGE_LIMIT = 1'b0;
	localparam logic REG_WINDOW     = 1'b1;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUB,
		ST_CHK,
		ST_REV,
		ST_MUL,
		ST_QUO,
		ST_QUOW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

// ===== rtl/core/ftrm_ifs.sv =====
`timescale 1ns / 1ps

interface ftrm_samp_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic        sense_level;
	logic [63:0] time_ns;

	modport source (output valid, output op, output sense_level, output time_ns, input ready);
	modport sink (input valid, input op, input sense_level, input time_ns, output ready);
endinterface

interface ftrm_res_if;
	logic        valid;
	logic        ready;
	logic [19:0] rpm;
	logic [7:0]  edge_count;
	logic        timed_out;

	modport source (output valid, output rpm, output edge_count, output timed_out, input ready);
	modport sink (input valid, input rpm, input edge_count, input timed_out, output ready);
endinterface

// ===== rtl/core/ftrm_regs.sv =====
`timescale 1ns / 1ps

module ftrm_regs
	import ftrm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [CNT_W-1:0]  edge_limit,
	output logic [WIN_W-1:0]  window_ns
);

	logic [CNT_W-1:0] edge_limit_q;
	logic [WIN_W-1:0] window_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_limit_q <= EDGE_LIMIT_RST;
			window_q     <= WINDOW_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_EDGE_LIMIT: edge_limit_q <= pwdata[CNT_W-1:0];
				REG_WINDOW:     window_q     <= pwdata[WIN_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EDGE_LIMIT: prdata = {{(DATA_W-CNT_W){1'b0}}, edge_limit_q};
			REG_WINDOW:     prdata = window_q;
			default:        prdata = '0;
		endcase
	end

	assign edge_limit = edge_limit_q;
	assign window_ns  = window_q;

endmodule

// ===== rtl/core/ftrm_div.sv =====
`timescale 1ns / 1ps

module ftrm_div
	import ftrm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic [NUM_W-1:0]  quotient,
	output logic              busy,
	output logic              done
);

	logic [TIME_W:0]     rem_q;
	logic [NUM_W-1:0]    dvd_q;
	logic [TIME_W-1:0]   dsr_q;
	logic [NUM_W-1:0]    quo_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [TIME_W:0]     rem_sh;
	logic [TIME_W:0]     rem_sub;
	logic                take;

	assign rem_sh  = {rem_q[TIME_W-1:0], dvd_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign take    = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub : rem_sh;
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/fan_tach_rpm_meter.sv =====
`timescale 1ns / 1ps

// Fan tachometer speed meter. A start transfer (op 0) opens a measurement and
// a sample transfer (op 1) counts a change of the sense level; the sample on
// which the edge count reaches edge_limit or the elapsed time reaches
// window_ns yields one result with rpm = 60e9 * floor((edges-1)/EDGES_PER_REV)
// / elapsed_ns, saturated at 1048575. A start transfer is taken in the idle
// state alone; a sample passes the elapsed-time and check states, and one that
// ends a measurement also passes a single restoring divider that forms the rpm
// quotient (44 steps, one bit a cycle); the revolution count comes from a
// reciprocal multiply by the constant EDGES_PER_REV. With no edge or zero
// elapsed time the multiply and the divider are skipped. The input is not
// ready while an item is at work; a finished result waits in an output register
// while the next transfer is taken, and a sample that ends a measurement is
// held in its final state for as long as the previous result still waits.
module fan_tach_rpm_meter
	import ftrm_pkg::*;
#(
	parameter int EDGES_PER_REV = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	ftrm_samp_if.sink         samp,
	ftrm_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int REV_SH = 16;
	localparam logic [REV_SH:0] REV_RECIP =
		(REV_SH+1)'(((1 << REV_SH) + EDGES_PER_REV - 1) / EDGES_PER_REV);

	state_t state_q, state_nx;

	logic [CNT_W-1:0]  edge_limit;
	logic [WIN_W-1:0]  window_ns;

	logic              prev_q;
	logic [CNT_W-1:0]  edges_q;
	logic [TIME_W-1:0] start_q;
	logic              measuring_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              zero_q;
	logic              tout_q;
	logic [CNT_W-1:0]  revs_q;
	logic [NUM_W-1:0]  num_q;

	logic              res_valid_q;
	logic [RPM_W-1:0]  rpm_q;
	logic [CNT_W-1:0]  cnt_out_q;
	logic              tout_out_q;

	logic              edge_done;
	logic              time_done;
	logic              accept;
	logic              res_free;

	div_req_t          div_req;
	logic [NUM_W-1:0]  div_dvd;
	logic [TIME_W-1:0] div_dsr;
	logic [NUM_W-1:0]  div_quo;
	logic              div_busy;
	logic              div_done;
	logic [CNT_W-1:0]  edges_dec;
	logic [CNT_W+REV_SH-1:0] rev_prod;
	logic [NUM_W-1:0]  product;
	logic [RPM_W-1:0]  rpm_sat;

	ftrm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.edge_limit (edge_limit),
		.window_ns  (window_ns)
	);

	ftrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign accept    = samp.valid && samp.ready;
	assign edge_done = edges_q >= edge_limit;
	assign time_done = elapsed_q >= {{(TIME_W-WIN_W){1'b0}}, window_ns};
	assign res_free  = !res_valid_q || res.ready;
	assign edges_dec = edges_q - CNT_W'(1);
	assign rev_prod  = (CNT_W+REV_SH)'(edges_dec) * (CNT_W+REV_SH)'(REV_RECIP);
	assign product   = NUM_W'(revs_q) * NUM_W'(NS_PER_MINUTE);
	assign rpm_sat   = (|div_quo[NUM_W-1:RPM_W]) ? RPM_MAX : div_quo[RPM_W-1:0];

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (samp.valid && samp.op == OP_SAMPLE && measuring_q)
					state_nx = ST_SUB;
			end
			ST_SUB:  state_nx = ST_CHK;
			ST_CHK: begin
				if (!edge_done && !time_done)
					state_nx = ST_IDLE;
				else if (edges_q == '0 || elapsed_q == '0)
					state_nx = ST_FIN;
				else
					state_nx = ST_REV;
			end
			ST_REV:  state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_QUO;
			ST_QUO:  state_nx = ST_QUOW;
			ST_QUOW: begin
				if (div_done)
					state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (res_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		samp.ready    = 1'b0;
		div_req.start = 1'b0;
		div_req.steps = STEP_W'(NUM_W);
		div_dvd       = num_q;
		div_dsr       = elapsed_q;
		unique case (state_q)
			ST_IDLE: samp.ready = 1'b1;
			ST_QUO:  div_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= 1'b0;
			edges_q     <= '0;
			start_q     <= '0;
			measuring_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				if (samp.op == OP_START) begin
					start_q     <= samp.time_ns;
					prev_q      <= samp.sense_level;
					edges_q     <= '0;
					measuring_q <= 1'b1;
				end else if (measuring_q && samp.sense_level != prev_q) begin
					prev_q <= samp.sense_level;
					if (edges_q != {CNT_W{1'b1}})
						edges_q <= edges_q + 1'b1;
				end
			end
			if (state_q == ST_CHK && (edge_done || time_done))
				measuring_q <= 1'b0;
			if (state_q == ST_FIN && res_free)
				res_valid_q <= 1'b1;
			else if (res.valid && res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			now_q <= samp.time_ns;
		if (state_q == ST_SUB)
			elapsed_q <= now_q - start_q;
		if (state_q == ST_CHK) begin
			zero_q <= (edges_q == '0) || (elapsed_q == '0);
			tout_q <= !edge_done;
		end
		if (state_q == ST_REV)
			revs_q <= rev_prod[CNT_W+REV_SH-1:REV_SH];
		if (state_q == ST_MUL)
			num_q <= product;
		if (state_q == ST_FIN && res_free) begin
			rpm_q      <= zero_q ? '0 : rpm_sat;
			cnt_out_q  <= edges_q;
			tout_out_q <= tout_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.rpm        = rpm_q;
	assign res.edge_count = cnt_out_q;
	assign res.timed_out  = tout_out_q;

	a_fin_closes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !measuring_q)
		else $error("result pending while measurement still open");

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		samp.ready |-> !div_busy)
		else $error("input ready while divider busy");

	a_no_edge_rpm: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.edge_count == '0 |-> res.rpm == '0)
		else $error("non-zero rpm with no edge counted");

endmodule
